// ===== hw/rtl/bpc_pkg.sv =====
// Shared types and constants for the barometric pressure compensation block.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package bpc_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 48;
	localparam int unsigned RAW_W = 24;
	localparam int unsigned TEMP_W = 16;
	localparam int unsigned PRES_W = 20;
	localparam int unsigned B5_W = 28;
	localparam int unsigned DIV_W = 34;
	localparam int unsigned MUL_A_W = 64;
	localparam int unsigned MUL_B_W = 40;
	localparam int unsigned MUL_DIGITS = MUL_B_W / 8;

	localparam logic signed [63:0] B6_OFFSET = 64'sd4000;
	localparam logic [15:0] B7_SCALE = 16'd50000;
	localparam logic signed [39:0] P_SQ_GAIN = 40'sd3038;
	localparam logic signed [39:0] P_LIN_GAIN = -40'sd7357;
	localparam logic signed [63:0] P_BIAS = 64'sd3791;
	localparam logic [31:0] X3_BIAS = 32'd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OSS   = 3'd0,
		CFG_AC123 = 3'd1,
		CFG_AC456 = 3'd2,
		CFG_B12   = 3'd3,
		CFG_MCMD  = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_RUN,
		CS_DONE
	} ctrl_state_t;

	typedef enum logic [3:0] {
		STP_T_MUL,
		STP_T_DIV,
		STP_T_FIN,
		STP_P_B6,
		STP_P_SQ,
		STP_P_X1,
		STP_P_T,
		STP_P_B3,
		STP_P_B4IN,
		STP_P_B7IN,
		STP_P_DIV,
		STP_P_H,
		STP_P_HH,
		STP_P_X1B,
		STP_P_FIN
	} step_t;

	typedef struct packed {
		logic  load_in;
		logic  go;
		step_t step;
		logic  load_out;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic abort;
	} status_t;

	typedef struct packed {
		logic                  valid;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

endpackage

// ===== hw/rtl/bpc_if.sv =====
// Channel interfaces: raw reading requests, result requests and register writes.
// Depends on bpc_pkg for field widths.
`timescale 1ns / 1ps

interface bpc_meas_if;
	import bpc_pkg::*;
	logic             valid;
	logic             ready;
	logic             kind;
	logic [RAW_W-1:0] raw_reading;
	modport source (output valid, kind, raw_reading, input ready);
	modport sink (input valid, kind, raw_reading, output ready);
endinterface

interface bpc_result_if;
	import bpc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     kind_out;
	logic signed [TEMP_W-1:0] temperature_tenths;
	logic [PRES_W-1:0]        pressure_pa;
	logic                     divide_error;
	modport source (output valid, kind_out, temperature_tenths, pressure_pa, divide_error,
		input ready);
	modport sink (input valid, kind_out, temperature_tenths, pressure_pa, divide_error,
		output ready);
endinterface

interface bpc_cfg_if;
	import bpc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/bpc_ctrl.sv =====
// Sequencer for the compensation block: accepts a request, walks the step list,
// hands the result to the output register. Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_ctrl
	import bpc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    meas_valid,
	input  logic    meas_kind,
	output logic    meas_ready,
	input  logic    out_ready,
	output logic    out_valid,
	input  status_t sts,
	output cmd_t    cmd
);

	ctrl_state_t state_q, state_d;
	step_t step_q, step_d, step_nxt;
	logic out_valid_q, out_valid_d;
	logic last_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			step_q <= STP_T_MUL;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		last_step = 1'b0;
		step_nxt = step_q;
		unique case (step_q)
			STP_T_MUL:  step_nxt = STP_T_DIV;
			STP_T_DIV:  step_nxt = STP_T_FIN;
			STP_T_FIN:  last_step = 1'b1;
			STP_P_B6:   step_nxt = STP_P_SQ;
			STP_P_SQ:   step_nxt = STP_P_X1;
			STP_P_X1:   step_nxt = STP_P_T;
			STP_P_T:    step_nxt = STP_P_B3;
			STP_P_B3:   step_nxt = STP_P_B4IN;
			STP_P_B4IN: step_nxt = STP_P_B7IN;
			STP_P_B7IN: step_nxt = STP_P_DIV;
			STP_P_DIV:  step_nxt = STP_P_H;
			STP_P_H:    step_nxt = STP_P_HH;
			STP_P_HH:   step_nxt = STP_P_X1B;
			STP_P_X1B:  step_nxt = STP_P_FIN;
			STP_P_FIN:  last_step = 1'b1;
			default:    last_step = 1'b1;
		endcase
	end

	always_comb begin
		state_d = state_q;
		step_d = step_q;
		cmd = '0;
		cmd.step = step_q;
		unique case (state_q)
			CS_IDLE: begin
				if (meas_valid) begin
					cmd.load_in = 1'b1;
					step_d = meas_kind ? STP_P_B6 : STP_T_MUL;
					state_d = CS_RUN;
				end
			end
			CS_RUN: begin
				if (!sts.busy) begin
					cmd.go = 1'b1;
					if (sts.abort || last_step) begin
						state_d = CS_DONE;
					end else begin
						step_d = step_nxt;
					end
				end
			end
			CS_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (cmd.load_out) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end
	end

	assign meas_ready = (state_q == CS_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/bpc_dp.sv =====
// Datapath: calibration registers, kept B5, shared serial multiplier and divider,
// step arithmetic and the output payload register. Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_dp
	import bpc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output status_t                  sts,
	input  cfg_wr_t                  cfg_wr,
	input  logic                     meas_kind,
	input  logic [RAW_W-1:0]         meas_raw,
	output logic                     out_kind,
	output logic signed [TEMP_W-1:0] out_temp,
	output logic [PRES_W-1:0]        out_pres,
	output logic                     out_err
);

	logic [1:0]  oss_q;
	logic [47:0] ac123_q, ac456_q;
	logic [31:0] b12_q, mcmd_q;
	logic signed [B5_W-1:0] b5_q;

	logic             kind_q;
	logic [RAW_W-1:0] raw_q;

	logic signed [MUL_A_W-1:0] ma_q, macc_q;
	logic signed [MUL_B_W-1:0] mb_q;
	logic [2:0] mcnt_q;
	logic mbusy_q;
	logic signed [8:0] mdig;

	logic [DIV_W-1:0] dq_q, dvs_q;
	logic [DIV_W:0]   drem_q, drem_sh;
	logic [5:0] dcnt_q;
	logic dbusy_q, dneg_q;

	logic signed [28:0] b6_q;
	logic signed [45:0] sq_q;
	logic signed [63:0] acc_q, b3_q;
	logic [23:0] up_q;
	logic [DIV_W-1:0] b4_q, p_q;
	logic p_dbl_q;

	logic signed [TEMP_W-1:0] temp_res_q;
	logic [PRES_W-1:0] pres_res_q;
	logic err_res_q;

	logic signed [15:0] ac1_s, ac2_s, ac3_s, b1_s, b2_s, mc_s, md_s;
	logic [15:0] ac4_u, ac5_u, ac6_u;

	logic signed [63:0] t_x1, t_den, t_num, t_num_mag, t_den_mag, q64, t_b5, t_tmp;
	logic signed [63:0] p_b6, p_t, p_b3, p_x3, p_fin;
	logic [31:0] p_u, p_diff, p_b7;
	logic [15:0] p_scale;
	logic [23:0] p_up;
	logic [DIV_W-1:0] p_b4, p_p;

	logic mul_start, div_start;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic [DIV_W-1:0] div_num, div_den;
	logic div_neg;

	function automatic logic [23:0] meas_raw_shift(input logic [23:0] raw, input logic [1:0] oss);
		logic [3:0] sh;
		sh = 4'd8 - {2'b0, oss};
		return raw >> sh;
	endfunction

	assign ac1_s = ac123_q[47:32];
	assign ac2_s = ac123_q[31:16];
	assign ac3_s = ac123_q[15:0];
	assign ac4_u = ac456_q[47:32];
	assign ac5_u = ac456_q[31:16];
	assign ac6_u = ac456_q[15:0];
	assign b1_s = b12_q[31:16];
	assign b2_s = b12_q[15:0];
	assign mc_s = mcmd_q[31:16];
	assign md_s = mcmd_q[15:0];

	// temperature terms
	assign t_x1 = macc_q >>> 15;
	assign t_den = t_x1 + 64'(md_s);
	assign t_num = 64'(mc_s) <<< 11;
	assign t_num_mag = t_num[63] ? -t_num : t_num;
	assign t_den_mag = t_den[63] ? -t_den : t_den;
	assign q64 = $signed({30'b0, dq_q});
	assign t_b5 = acc_q + (dneg_q ? -q64 : q64);
	assign t_tmp = (t_b5 + 64'sd8) >>> 4;

	// pressure terms
	assign p_b6 = 64'(b5_q) - B6_OFFSET;
	assign p_up = meas_raw_shift(raw_q, oss_q);
	assign p_t = acc_q + (macc_q >>> 11) + (64'(ac1_s) <<< 2);
	assign p_b3 = ((acc_q <<< oss_q) + 64'sd2) >>> 2;
	assign p_x3 = (acc_q + (macc_q >>> 16) + 64'sd2) >>> 2;
	assign p_u = p_x3[31:0] + X3_BIAS;
	assign p_b4 = macc_q[48:15];
	assign p_diff = {8'b0, up_q} - b3_q[31:0];
	assign p_scale = B7_SCALE >> oss_q;
	assign p_b7 = macc_q[31:0];
	assign p_p = p_dbl_q ? {dq_q[DIV_W-2:0], 1'b0} : dq_q;
	assign p_fin = $signed({30'b0, p_q}) + ((acc_q + (macc_q >>> 16) + P_BIAS) >>> 4);

	always_comb begin
		sts.busy = mbusy_q | dbusy_q;
		sts.abort = 1'b0;
		if (cmd.step == STP_T_DIV && t_den == 64'sd0) begin
			sts.abort = 1'b1;
		end
		if (cmd.step == STP_P_B7IN && p_b4 == '0) begin
			sts.abort = 1'b1;
		end
	end

	// operand selection for the shared units
	always_comb begin
		mul_start = 1'b0;
		div_start = 1'b0;
		mul_a = '0;
		mul_b = '0;
		div_num = '0;
		div_den = '0;
		div_neg = 1'b0;
		unique case (cmd.step)
			STP_T_MUL: begin
				mul_start = 1'b1;
				mul_a = $signed({48'b0, raw_q[15:0]}) - $signed({48'b0, ac6_u});
				mul_b = $signed({24'b0, ac5_u});
			end
			STP_T_DIV: begin
				div_start = !sts.abort;
				div_num = t_num_mag[DIV_W-1:0];
				div_den = t_den_mag[DIV_W-1:0];
				div_neg = t_num[63] ^ t_den[63];
			end
			STP_P_B6: begin
				mul_start = 1'b1;
				mul_a = p_b6;
				mul_b = p_b6[MUL_B_W-1:0];
			end
			STP_P_SQ: begin
				mul_start = 1'b1;
				mul_a = macc_q >>> 12;
				mul_b = 40'(b2_s);
			end
			STP_P_X1: begin
				mul_start = 1'b1;
				mul_a = 64'(b6_q);
				mul_b = 40'(ac2_s);
			end
			STP_P_T: begin
				mul_start = 1'b1;
				mul_a = 64'(b6_q);
				mul_b = 40'(ac3_s);
			end
			STP_P_B3: begin
				mul_start = 1'b1;
				mul_a = 64'(sq_q);
				mul_b = 40'(b1_s);
			end
			STP_P_B4IN: begin
				mul_start = 1'b1;
				mul_a = $signed({32'b0, p_u});
				mul_b = $signed({24'b0, ac4_u});
			end
			STP_P_B7IN: begin
				mul_start = !sts.abort;
				mul_a = $signed({32'b0, p_diff});
				mul_b = $signed({24'b0, p_scale});
			end
			STP_P_DIV: begin
				div_start = 1'b1;
				div_num = p_b7[31] ? {2'b0, p_b7} : {1'b0, p_b7, 1'b0};
				div_den = b4_q;
			end
			STP_P_H: begin
				mul_start = 1'b1;
				mul_a = $signed({38'b0, p_p[DIV_W-1:8]});
				mul_b = $signed({14'b0, p_p[DIV_W-1:8]});
			end
			STP_P_HH: begin
				mul_start = 1'b1;
				mul_a = macc_q;
				mul_b = P_SQ_GAIN;
			end
			STP_P_X1B: begin
				mul_start = 1'b1;
				mul_a = $signed({30'b0, p_q});
				mul_b = P_LIN_GAIN;
			end
			default: begin
			end
		endcase
	end

	// configuration registers and kept B5
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oss_q <= '0;
			ac123_q <= '0;
			ac456_q <= '0;
			b12_q <= '0;
			mcmd_q <= '0;
			b5_q <= '0;
		end else begin
			if (cfg_wr.valid) begin
				case (cfg_wr.index)
					CFG_OSS:   oss_q <= cfg_wr.data[1:0];
					CFG_AC123: ac123_q <= cfg_wr.data;
					CFG_AC456: ac456_q <= cfg_wr.data;
					CFG_B12:   b12_q <= cfg_wr.data[31:0];
					CFG_MCMD:  mcmd_q <= cfg_wr.data[31:0];
					default: begin
					end
				endcase
			end
			if (cmd.go && cmd.step == STP_T_FIN) begin
				b5_q <= t_b5[B5_W-1:0];
			end
		end
	end

	// serial multiplier: one 8-bit digit of B per cycle, top digit signed
	assign mdig = (mcnt_q == 3'(MUL_DIGITS - 1)) ? {mb_q[7], mb_q[7:0]} : {1'b0, mb_q[7:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
		end else if (cmd.go && mul_start) begin
			mbusy_q <= 1'b1;
		end else if (mbusy_q && mcnt_q == 3'(MUL_DIGITS - 1)) begin
			mbusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go && mul_start) begin
			ma_q <= mul_a;
			mb_q <= mul_b;
			macc_q <= '0;
			mcnt_q <= '0;
		end else if (mbusy_q) begin
			macc_q <= macc_q + ma_q * mdig;
			ma_q <= ma_q <<< 8;
			mb_q <= mb_q >>> 8;
			mcnt_q <= mcnt_q + 3'd1;
		end
	end

	// serial restoring divider: one quotient bit per cycle
	assign drem_sh = {drem_q[DIV_W-1:0], dq_q[DIV_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
		end else if (cmd.go && div_start) begin
			dbusy_q <= 1'b1;
		end else if (dbusy_q && dcnt_q == 6'(DIV_W - 1)) begin
			dbusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go && div_start) begin
			dq_q <= div_num;
			dvs_q <= div_den;
			drem_q <= '0;
			dcnt_q <= '0;
			dneg_q <= div_neg;
			p_dbl_q <= p_b7[31];
		end else if (dbusy_q) begin
			dcnt_q <= dcnt_q + 6'd1;
			if (drem_sh >= {1'b0, dvs_q}) begin
				drem_q <= drem_sh - {1'b0, dvs_q};
				dq_q <= {dq_q[DIV_W-2:0], 1'b1};
			end else begin
				drem_q <= drem_sh;
				dq_q <= {dq_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	// step results
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q <= meas_kind;
			raw_q <= meas_raw;
			temp_res_q <= '0;
			pres_res_q <= '0;
			err_res_q <= 1'b0;
		end else if (cmd.go) begin
			if (sts.abort) begin
				err_res_q <= 1'b1;
			end
			unique case (cmd.step)
				STP_T_DIV: acc_q <= t_x1;
				STP_T_MUL: acc_q <= acc_q;
				STP_T_FIN: begin
					if (t_tmp > 64'sd32767) begin
						temp_res_q <= 16'sh7FFF;
					end else if (t_tmp < -64'sd32768) begin
						temp_res_q <= 16'sh8000;
					end else begin
						temp_res_q <= t_tmp[TEMP_W-1:0];
					end
				end
				STP_P_B6: begin
					b6_q <= p_b6[28:0];
					up_q <= p_up;
				end
				STP_P_SQ: sq_q <= 46'(macc_q >>> 12);
				STP_P_X1: acc_q <= macc_q >>> 11;
				STP_P_T: acc_q <= p_t;
				STP_P_B3: begin
					b3_q <= p_b3;
					acc_q <= macc_q >>> 13;
				end
				STP_P_B4IN: acc_q <= acc_q;
				STP_P_B7IN: b4_q <= p_b4;
				STP_P_DIV: acc_q <= acc_q;
				STP_P_H: p_q <= p_p;
				STP_P_HH: acc_q <= acc_q;
				STP_P_X1B: acc_q <= macc_q >>> 16;
				STP_P_FIN: begin
					if (p_fin < 64'sd0) begin
						pres_res_q <= '0;
					end else if (p_fin > 64'sd1048575) begin
						pres_res_q <= '1;
					end else begin
						pres_res_q <= p_fin[PRES_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_kind <= kind_q;
			out_temp <= temp_res_q;
			out_pres <= pres_res_q;
			out_err <= err_res_q;
		end
	end

endmodule

// ===== hw/rtl/barometric_pressure_compensation.sv =====
// Top level of the barometric pressure compensation block: channel wiring,
// controller and datapath. Depends on bpc_pkg, bpc_if, bpc_ctrl and bpc_dp.
`timescale 1ns / 1ps

// Channel  Dir  Payload                                              Handshake
// meas     in   kind, raw_reading                                    valid/ready
// result   out  kind_out, temperature_tenths, pressure_pa, divide_error valid/ready
// cfg      in   index, data (register write)                         valid/ready
//
// One request at a time. A temperature request takes one pass of the shared
// multiplier (start plus five digits) and one pass of the serial divider. A
// pressure request takes ten multiplier passes plus one divider pass, all on
// the shared 64x8 multiplier and the 1-bit-per-cycle divider. Reset clears
// the configuration registers and the kept B5 to zero. A finished result sits
// in the output register while the next request is accepted; the block only
// holds in its final step if that register is still full. Register writes are
// taken in any cycle.

module barometric_pressure_compensation
	import bpc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	bpc_meas_if.sink        meas,
	bpc_result_if.source    result,
	bpc_cfg_if.sink         cfg
);

	cmd_t    cmd;
	status_t sts;
	cfg_wr_t cfg_wr;

	// register writes are always accepted
	assign cfg.ready = 1'b1;
	assign cfg_wr.valid = cfg.valid;
	assign cfg_wr.index = cfg.index;
	assign cfg_wr.data = cfg.data;

	bpc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.meas_valid (meas.valid),
		.meas_kind  (meas.kind),
		.meas_ready (meas.ready),
		.out_ready  (result.ready),
		.out_valid  (result.valid),
		.sts        (sts),
		.cmd        (cmd)
	);

	bpc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_wr    (cfg_wr),
		.meas_kind (meas.kind),
		.meas_raw  (meas.raw_reading),
		.out_kind  (result.kind_out),
		.out_temp  (result.temperature_tenths),
		.out_pres  (result.pressure_pa),
		.out_err   (result.divide_error)
	);

	// a request drops ready until its result has been loaded into the output register
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		meas.valid && meas.ready |=> !meas.ready)
		else $error("request accepted while another is in flight");

	// a temperature result carries no pressure and the reverse
	a_kind_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.kind_out ? result.temperature_tenths == 16'sd0
			: result.pressure_pa == '0))
		else $error("result field set for the wrong reading kind");

	// a divide error zeroes both result fields
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.divide_error |->
			result.pressure_pa == '0 && result.temperature_tenths == 16'sd0)
		else $error("divide error with nonzero result");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for barometric_pressure_compensation: drives raw readings and
// register writes, predicts each compensated result and checks it. Needs bpc_pkg and bpc_if.
`timescale 1ns / 1ps

module testbench;
	import bpc_pkg::*;

	// Expected compensated reading, one per accepted request
	typedef struct {
		logic                     kind;
		logic signed [TEMP_W-1:0] temp;
		logic [PRES_W-1:0]        pres;
		logic                     err;
	} reading_t;

	logic clk;
	logic arst_n;

	bpc_meas_if   meas_ch();
	bpc_result_if result_ch();
	bpc_cfg_if    cfg_ch();

	barometric_pressure_compensation u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.meas   (meas_ch.sink),
		.result (result_ch.source),
		.cfg    (cfg_ch.sink)
	);

	// Shadow copy of the register file and the kept B5
	logic [1:0]  oss_reg;
	logic [47:0] ac123_reg;
	logic [47:0] ac456_reg;
	logic [31:0] b12_reg;
	logic [31:0] mcmd_reg;
	int          kept_b5;

	reading_t pending_readings[$];
	bit       any_failure;
	bit       sink_hold;     // long receiver hold-off
	bit       no_idle;       // stretch with no gaps or stalls
	int       sink_stall;

	always #6 clk = ~clk;

	// Integer datasheet compensation at the block's widths
	function automatic reading_t compensate(logic kind, logic [RAW_W-1:0] raw);
		reading_t r;
		longint ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
		longint unsigned ac4, b4, pu;
		longint ut, x1, x2, x3, den, b5, b6, sq, b3, p, h;
		bit [31:0] up32, b7;
		int unsigned oss;
		ac1 = longint'($signed(ac123_reg[47:32]));
		ac2 = longint'($signed(ac123_reg[31:16]));
		ac3 = longint'($signed(ac123_reg[15:0]));
		ac4 = longint'(ac456_reg[47:32]);
		ac5 = longint'(ac456_reg[31:16]);
		ac6 = longint'(ac456_reg[15:0]);
		b1 = longint'($signed(b12_reg[31:16]));
		b2 = longint'($signed(b12_reg[15:0]));
		mc = longint'($signed(mcmd_reg[31:16]));
		md = longint'($signed(mcmd_reg[15:0]));
		oss = oss_reg;
		r.kind = kind;
		r.temp = '0;
		r.pres = '0;
		r.err = 1'b0;
		if (kind == 1'b0) begin
			ut = longint'(raw[15:0]);
			x1 = ((ut - ac6) * ac5) >>> 15;
			den = x1 + md;
			if (den == 0) begin
				// keep B5 untouched on a zero divisor
				r.err = 1'b1;
			end else begin
				b5 = x1 + (mc * 2048) / den;
				kept_b5 = int'(b5);
				b5 = (b5 + 8) >>> 4;
				if (b5 > 32767) b5 = 32767;
				if (b5 < -32768) b5 = -32768;
				r.temp = b5[15:0];
			end
		end else begin
			up32 = 32'(raw >> (8 - oss));
			b6 = longint'(kept_b5) - 4000;
			sq = (b6 * b6) >>> 12;
			x1 = (b2 * sq) >>> 11;
			x2 = (ac2 * b6) >>> 11;
			x3 = x1 + x2;
			b3 = ((ac1 * 4 + x3) * (longint'(1) << oss) + 2) >>> 2;
			x1 = (ac3 * b6) >>> 13;
			x2 = (b1 * sq) >>> 16;
			x3 = (x1 + x2 + 2) >>> 2;
			b4 = (ac4 * {32'b0, 32'(x3 + 32768)}) >> 15;
			b7 = (up32 - 32'(b3)) * 32'(50000 >> oss);
			if (b4 == 0) begin
				r.err = 1'b1;
			end else begin
				if (b7 < 32'h8000_0000)
					pu = (longint'(b7) * 2) / b4;
				else
					pu = (longint'(b7) / b4) * 2;
				p = longint'(pu);
				h = p >>> 8;
				x1 = ((h * h) * 3038) >>> 16;
				x2 = (-7357 * p) >>> 16;
				p = p + ((x1 + x2 + 3791) >>> 4);
				if (p > 1048575) p = 1048575;
				if (p < 0) p = 0;
				r.pres = p[19:0];
			end
		end
		return r;
	endfunction

	// Send one raw reading request; valid stays high for a back-to-back follower
	task automatic send_reading(logic kind, logic [RAW_W-1:0] raw);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			meas_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		meas_ch.valid = 1'b1;
		meas_ch.kind = kind;
		meas_ch.raw_reading = raw;
		do @(posedge clk); while (!meas_ch.ready);
		pending_readings.push_back(compensate(kind, raw));
		@(negedge clk);
	endtask

	// Drop valid and let the block drain every outstanding request
	task automatic drain();
		meas_ch.valid = 1'b0;
		while (pending_readings.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = value;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_OSS:   oss_reg = value[1:0];
			CFG_AC123: ac123_reg = value[47:0];
			CFG_AC456: ac456_reg = value[47:0];
			CFG_B12:   b12_reg = value[31:0];
			CFG_MCMD:  mcmd_reg = value[31:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic load_datasheet_cal(logic [1:0] oss);
		drain();
		write_reg(CFG_OSS, 48'(oss));
		write_reg(CFG_AC123, {16'd408, 16'hFFB8, 16'hC7D1});
		write_reg(CFG_AC456, {16'd32741, 16'd32757, 16'd23153});
		write_reg(CFG_B12, 48'({16'd6190, 16'd4}));
		write_reg(CFG_MCMD, 48'({16'hDDF9, 16'd2868}));
	endtask

	// Reset values: zero divisors on both paths
	task automatic test_reset_defaults();
		send_reading(1'b0, 24'h00_6CFA);
		send_reading(1'b1, 24'hFF_FFFF);
		send_reading(1'b1, 24'h00_0000);
	endtask

	// Typical calibration, every oversampling setting, field extremes
	task automatic test_datasheet();
		for (int o = 0; o < 4; o++) begin
			load_datasheet_cal(o[1:0]);
			send_reading(1'b0, 24'hAB_6CFA);
			send_reading(1'b1, 24'h5D_2300);
			send_reading(1'b1, 24'hFF_FFFF);
			send_reading(1'b1, 24'h00_0000);
		end
		send_reading(1'b0, 24'hFF_FFFF);
		send_reading(1'b0, 24'h00_0000);
	endtask

	// Zero temperature divisor, then saturation in both directions
	task automatic test_corners();
		drain();
		// AC5 = 32768 makes X1 = UT - AC6; MD cancels it for UT = 50
		write_reg(CFG_AC456, {16'd32741, 16'd32768, 16'd100});
		write_reg(CFG_MCMD, 48'({16'h7FFF, 16'd50}));
		send_reading(1'b0, 24'h00_0032);
		send_reading(1'b1, 24'h80_0000);   // uses the B5 left over
		send_reading(1'b0, 24'h00_0033);   // tiny divisor, temperature saturates high
		send_reading(1'b1, 24'h12_3456);
		drain();
		write_reg(CFG_MCMD, 48'({16'h8000, 16'd50}));
		send_reading(1'b0, 24'h00_0033);   // saturates low
		send_reading(1'b1, 24'hFF_FFFF);
	endtask

	task automatic random_cal(bit realistic);
		drain();
		write_reg(CFG_OSS, 48'($urandom_range(0, 3)));
		if (realistic) begin
			write_reg(CFG_AC123, {16'(408 + $urandom_range(0, 8000)),
				16'(-72 - int'($urandom_range(0, 1200))), 16'(-14383 + $urandom_range(0, 4000))});
			write_reg(CFG_AC456, {16'(26000 + $urandom_range(0, 9000)),
				16'(24000 + $urandom_range(0, 9000)), 16'(16000 + $urandom_range(0, 9000))});
			write_reg(CFG_B12, 48'({16'(5000 + $urandom_range(0, 2000)),
				16'($urandom_range(0, 60))}));
			write_reg(CFG_MCMD, 48'({16'(-11786 + $urandom_range(0, 3000)),
				16'(2300 + $urandom_range(0, 700))}));
		end else begin
			write_reg(CFG_AC123, 48'({$urandom, $urandom}));
			write_reg(CFG_AC456, 48'({$urandom, $urandom}));
			write_reg(CFG_B12, 48'($urandom));
			write_reg(CFG_MCMD, 48'($urandom));
		end
	endtask

	// Phases of random calibration; mostly temperature-then-pressure pairs
	task automatic test_random_phases();
		logic [RAW_W-1:0] raw;
		for (int ph = 0; ph < 6; ph++) begin
			random_cal(ph % 3 != 2);
			no_idle = (ph == 1);
			for (int n = 0; n < 180; n++) begin
				raw = 24'($urandom);
				if ($urandom_range(0, 9) < 8) begin
					send_reading(1'b0, ph % 3 != 2 ? {raw[23:16], 16'(24000 + raw[13:0])} : raw);
					send_reading(1'b1, 24'($urandom));
				end else begin
					send_reading(1'(raw[0]), 24'($urandom));
				end
			end
			no_idle = 1'b0;
		end
	endtask

	// Hold off the receiver long enough to stall the input, then pause the sender
	task automatic test_backpressure();
		load_datasheet_cal(2'd3);
		sink_hold = 1'b1;
		fork
			begin
				repeat (800) @(negedge clk);
				sink_hold = 1'b0;
			end
			for (int n = 0; n < 6; n++) send_reading(1'(n), 24'($urandom));
		join
		drain();
		for (int n = 0; n < 10; n++) send_reading(1'(n), 24'($urandom));
	endtask

	// Receiver: draw a stall per result, or hold off entirely
	initial begin
		result_ch.ready = 1'b0;
		sink_stall = 0;
		forever begin
			@(negedge clk);
			if (sink_hold) begin
				result_ch.ready = 1'b0;
			end else if (sink_stall > 0 && !no_idle) begin
				result_ch.ready = 1'b0;
				sink_stall--;
			end else begin
				result_ch.ready = 1'b1;
			end
		end
	end

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin
		reading_t exp_r;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			sink_stall = $urandom_range(0, 6);
			if (pending_readings.size() == 0) begin
				$error("result with no request outstanding");
				any_failure = 1'b1;
			end else begin
				exp_r = pending_readings.pop_front();
				if (result_ch.kind_out !== exp_r.kind) begin
					$error("kind_out: expected %0d, got %0d", exp_r.kind, result_ch.kind_out);
					any_failure = 1'b1;
				end
				if (result_ch.temperature_tenths !== exp_r.temp) begin
					$error("temperature_tenths: expected %0d, got %0d", exp_r.temp,
						result_ch.temperature_tenths);
					any_failure = 1'b1;
				end
				if (result_ch.pressure_pa !== exp_r.pres) begin
					$error("pressure_pa: expected %0d, got %0d", exp_r.pres, result_ch.pressure_pa);
					any_failure = 1'b1;
				end
				if (result_ch.divide_error !== exp_r.err) begin
					$error("divide_error: expected %0d, got %0d", exp_r.err,
						result_ch.divide_error);
					any_failure = 1'b1;
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		meas_ch.valid = 1'b0;
		meas_ch.kind = 1'b0;
		meas_ch.raw_reading = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		oss_reg = '0;
		ac123_reg = '0;
		ac456_reg = '0;
		b12_reg = '0;
		mcmd_reg = '0;
		kept_b5 = 0;
		any_failure = 1'b0;
		sink_hold = 1'b0;
		no_idle = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_datasheet();
		test_corners();
		test_random_phases();
		test_backpressure();

		drain();
		repeat (150) @(negedge clk);
		if (!any_failure && pending_readings.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#40ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_if.sv
hw/rtl/bpc_ctrl.sv
hw/rtl/bpc_dp.sv
hw/rtl/barometric_pressure_compensation.sv
tb/sv/testbench.sv
